>>> rtl/core/mtrr_large_page_memory_type_unit_assert.svh
// ----------------------------------------------------------------------------
// MTRR large page memory type unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MTRR_LARGE_PAGE_MEMORY_TYPE_UNIT_ASSERT_SVH
`define MTRR_LARGE_PAGE_MEMORY_TYPE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MLPMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLPMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mtrr_lpmt_pkg.sv
// ----------------------------------------------------------------------------
// MTRR large page memory type package
// Request and result types, codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrr_lpmt_pkg;

  localparam int MAX_RANGES_DEF   = 16;
  localparam int PAGE_NUMBER_BITS = 18;
  localparam int PAGE_W           = 18;
  localparam int ADDR_K_W         = 40;  // address bits 51:12
  localparam int LAST_K_W         = 41;  // last address can carry into bit 52
  localparam int PAGE_K_SHIFT     = 9;   // 2 MB page in 4 KB units

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [7:0] TYPE_UC = 8'd0;
  localparam logic [7:0] TYPE_WB = 8'd6;
  localparam logic [2:0] MEM_UC  = 3'd0;
  localparam logic [2:0] MEM_WB  = 3'd6;

  localparam logic [2:0] RES_HOLD   = 3'd0;
  localparam logic [2:0] RES_ZERO   = 3'd1;
  localparam logic [2:0] RES_FULL   = 3'd2;
  localparam logic [2:0] RES_STORED = 3'd3;
  localparam logic [2:0] RES_UC     = 3'd4;
  localparam logic [2:0] RES_WB     = 3'd5;

  typedef struct packed {
    logic [1:0]        kind;
    logic [63:0]       base_word;
    logic [63:0]       mask_word;
    logic [PAGE_W-1:0] page_number;
  } in_t;

  typedef struct packed {
    logic [2:0] cache_type;
    logic       range_stored;
    logic       table_full;
  } out_t;

  typedef struct packed {
    logic [LAST_K_W-1:0] last_k;
    logic [ADDR_K_W-1:0] start_k;
    logic [7:0]          kind;
  } entry_t;

  typedef struct packed {
    logic       capture;
    logic       calc_mask;
    logic       wr_en;
    logic       clear_count;
    logic       scan_start;
    logic       rd_en;
    logic       check;
    logic       finish;
    logic [2:0] res_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       storable;
    logic       full;
    logic       empty;
    logic       page_zero;
    logic       uc_hit;
    logic       scan_end;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/mtrr_large_page_memory_type_unit.sv
// ----------------------------------------------------------------------------
// MTRR large page memory type unit
// Variable memory-type range table with a 2 MB page caching-type resolver.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Moves
//   --------  ----------------------------  ---------------------------------
//   in        in_valid, in_stall, in_data   one request: clear, load or query
//   out       out_valid, out_stall, out_data one result per request
//
// Steps: a request passes accept, decode and hand-off; a stored load adds a
//   table write, and a query of a non-zero page on a non-empty table adds a
//   read step and a check step per entry scanned. The scan reads the table
//   entries one at a time through the single RAM read port, and ends early at
//   the first uncacheable hit.
// Reset: clears the controller, the entry count and the output valid; table
//   contents are never read before being written, so no clearing pass runs.
// Stalls: a finished result waits in the output register; the next request
//   is accepted meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_large_page_memory_type_unit
  import mtrr_lpmt_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // controller-to-datapath commands and returning status
  cmd_t cmd;
  sts_t sts;

  // sequence each request: decode, write or scan, then hand off the result
  mtrr_lpmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // hold the range table, compare each entry against the page, drive the output
  mtrr_lpmt_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/mtrr_lpmt_ram.sv
// ----------------------------------------------------------------------------
// MTRR large page memory type: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_lpmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/mtrr_lpmt_ctrl.sv
// ----------------------------------------------------------------------------
// MTRR large page memory type: controller
// Sequences decode, range write, table scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mtrr_large_page_memory_type_unit_assert.svh"

module mtrr_lpmt_ctrl
  import mtrr_lpmt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt    = S_DONE;
        cmd_o.res_op = RES_ZERO;
        case (sts_i.kind)
          KIND_CLEAR: begin
            cmd_o.clear_count = 1'b1;
          end
          KIND_LOAD: begin
            if (sts_i.storable && sts_i.full) begin
              cmd_o.res_op = RES_FULL;
            end else if (sts_i.storable) begin
              cmd_o.res_op    = RES_STORED;
              cmd_o.calc_mask = 1'b1;
              state_nxt       = S_WRITE;
            end
          end
          KIND_QUERY: begin
            if (sts_i.page_zero) begin
              cmd_o.res_op = RES_UC;
            end else begin
              cmd_o.res_op     = RES_WB;
              cmd_o.scan_start = 1'b1;
              if (!sts_i.empty) begin
                state_nxt = S_READ;
              end
            end
          end
          default: begin
            cmd_o.res_op = RES_ZERO;
          end
        endcase
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_nxt   = S_DONE;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        // stop at the first uncacheable match or after the last entry
        if (sts_i.uc_hit || sts_i.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `MLPMT_ASSERT_IMP(a_write_not_full, cmd_o.wr_en, !sts_i.full, "range write into a full table")
  `MLPMT_ASSERT_IMP(a_finish_out_free, cmd_o.finish, sts_i.out_free, "result overwrites output")
  `MLPMT_ASSERT_NEXT(a_accept_decode, (state_r == S_IDLE) && in_valid, state_r == S_DECODE, "accepted request not decoded")

endmodule

`default_nettype wire

>>> rtl/core/mtrr_lpmt_dp.sv
// ----------------------------------------------------------------------------
// MTRR large page memory type: datapath
// Request capture, range table, overlap compare, result and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrr_lpmt_dp
  import mtrr_lpmt_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int KEEP   = (PAGE_NUMBER_BITS < PAGE_W) ? PAGE_NUMBER_BITS : PAGE_W;
  localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((64'd1 << KEEP) - 64'd1);

  // captured request
  logic [1:0]          kind_r;
  logic [ADDR_K_W-1:0] start_k_r;
  logic [7:0]          type_r;
  logic [ADDR_K_W-1:0] mask_k_r;
  logic                mask_valid_r;
  logic [PAGE_W-1:0]   page_r;

  logic [ADDR_K_W-1:0] low_mask_r;
  logic [ADDR_K_W-1:0] low_mask_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [ADDR_W-1:0]   idx_r;
  out_t                res_r;
  out_t                res_nxt;
  out_t                out_r;
  logic                out_valid_r;

  entry_t              wr_entry;
  entry_t              rd_entry;
  logic [LAST_K_W-1:0] first_k;
  logic [ADDR_K_W-1:0] last_k;
  logic                overlap;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      kind_r       <= in_data.kind;
      start_k_r    <= in_data.base_word[51:12];
      type_r       <= in_data.base_word[7:0];
      mask_k_r     <= in_data.mask_word[51:12];
      mask_valid_r <= in_data.mask_word[11];
      page_r       <= in_data.page_number & PAGE_MASK;
    end
    if (cmd_i.calc_mask) begin
      low_mask_r <= low_mask_nxt;
    end
  end

  // ones below the lowest set bit of the mask field
  assign low_mask_nxt = (mask_k_r ^ (mask_k_r - ADDR_K_W'(1))) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd_i.clear_count) begin
      count_r <= '0;
    end else if (cmd_i.wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd_i.scan_start) begin
      idx_r <= '0;
    end else if (cmd_i.check) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  assign wr_entry.start_k = start_k_r;
  assign wr_entry.last_k  = {1'b0, start_k_r} + {1'b0, low_mask_r};
  assign wr_entry.kind    = type_r;

  mtrr_lpmt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd_i.wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (cmd_i.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_entry)
  );

  // page bounds in 4 KB units; the entry's low 12 address bits are implied
  assign first_k = LAST_K_W'({page_r, {PAGE_K_SHIFT{1'b0}}});
  assign last_k  = ADDR_K_W'({page_r, {PAGE_K_SHIFT{1'b1}}});
  assign overlap = (first_k <= rd_entry.last_k) && (last_k >= rd_entry.start_k);

  always_comb begin
    res_nxt = res_r;
    case (cmd_i.res_op)
      RES_HOLD: begin
        res_nxt = res_r;
      end
      RES_ZERO: begin
        res_nxt = '0;
      end
      RES_FULL: begin
        res_nxt            = '0;
        res_nxt.table_full = 1'b1;
      end
      RES_STORED: begin
        res_nxt              = '0;
        res_nxt.range_stored = 1'b1;
      end
      RES_UC: begin
        res_nxt            = '0;
        res_nxt.cache_type = MEM_UC;
      end
      RES_WB: begin
        res_nxt            = '0;
        res_nxt.cache_type = MEM_WB;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
    if (cmd_i.check && overlap) begin
      res_nxt.cache_type = rd_entry.kind[2:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd_i.finish) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts_o.kind      = kind_r;
  assign sts_o.storable  = mask_valid_r && (type_r != TYPE_WB) && (mask_k_r != '0);
  assign sts_o.full      = (count_r == CNT_W'(MAX_RANGES));
  assign sts_o.empty     = (count_r == '0);
  assign sts_o.page_zero = (page_r == '0);
  assign sts_o.uc_hit    = overlap && (rd_entry.kind == TYPE_UC);
  assign sts_o.scan_end  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts_o.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
